[rtl/core/edd_pkg.sv]
// Shared types and constants for the echo drop detector.
// Depends on nothing; every other file of the block imports it.
`default_nettype none

package edd_pkg;

    // Field widths.
    localparam int ECHO_W      = 20;
    localparam int DIST_W      = 15;
    localparam int DROP_W      = 16;
    localparam int HOLD_CNT_W  = 10;
    localparam int HOLD_SAMP_W = 8;

    // Stream and configuration port widths.
    localparam int IN_TDATA_W  = 24;
    localparam int OUT_TDATA_W = 32;
    localparam int IDX_W       = 2;
    localparam int CFG_DATA_W  = 15;

    // Register indexes of the configuration port.
    localparam logic [IDX_W-1:0] REG_MAX_DISTANCE    = 2'd0;
    localparam logic [IDX_W-1:0] REG_DROP_THRESHOLD  = 2'd1;
    localparam logic [IDX_W-1:0] REG_HOLDOFF_SAMPLES = 2'd2;
    localparam logic [IDX_W-1:0] REG_DISTANCE_UNIT   = 2'd3;

    // Register reset values.
    localparam logic [DIST_W-1:0]      MAX_DISTANCE_RST    = 15'd400;
    localparam logic [DIST_W-1:0]      DROP_THRESHOLD_RST  = 15'd5;
    localparam logic [HOLD_SAMP_W-1:0] HOLDOFF_SAMPLES_RST = 8'd10;
    localparam logic                   DISTANCE_UNIT_RST   = 1'b0;

    // The holdoff after reset or a configuration write is this many times the setting.
    localparam int HOLDOFF_RESET_FACTOR = 4;
    localparam logic [HOLD_CNT_W-1:0] HOLDOFF_CNT_RST =
        HOLD_CNT_W'(HOLDOFF_RESET_FACTOR * int'(HOLDOFF_SAMPLES_RST));

    // Division by 58 or 148 as a multiplication by a rounded-up reciprocal.
    // The shift is large enough that the error stays below one for any 20-bit width.
    localparam int CM_DIVISOR = 58;
    localparam int IN_DIVISOR = 148;
    localparam int CM_SHIFT   = 26;
    localparam int IN_SHIFT   = 28;
    localparam int RECIP_W    = 21;
    localparam int PROD_W     = ECHO_W + RECIP_W;
    localparam logic [RECIP_W-1:0] CM_RECIP =
        RECIP_W'((64'd1 << CM_SHIFT) / CM_DIVISOR + 1);
    localparam logic [RECIP_W-1:0] IN_RECIP =
        RECIP_W'((64'd1 << IN_SHIFT) / IN_DIVISOR + 1);

    // Current register settings.
    typedef struct packed {
        logic [DIST_W-1:0]      max_distance;
        logic [DIST_W-1:0]      drop_threshold;
        logic [HOLD_SAMP_W-1:0] holdoff_samples;
        logic                   distance_unit;
    } cfg_t;

    // Restart request raised by a configuration write.
    typedef struct packed {
        logic                  strobe;
        logic [HOLD_CNT_W-1:0] holdoff;
    } restart_t;

endpackage

`default_nettype wire

[rtl/core/echo_drop_detector_with_holdoff_unit.sv]
// Top level of the echo drop detector: streams, configuration port and stage wiring.
// Depends on edd_pkg, edd_cfg, edd_divider and edd_detect.
`default_nettype none

// Each input word is one echo width in microseconds; each gives exactly one result word,
// in order, by way of the input, quotient and result registers. The width is divided by 58
// (cm) or 148 (inches) through a reciprocal multiply, clamped to max_distance, and compared
// with the previous distance; a drop above drop_threshold while the holdoff count is zero is
// a hit and rearms the holdoff with holdoff_samples. The block takes one word per cycle while
// the output is not stalled: the reciprocal multiplier has its own stage, and the holdoff and
// previous-distance registers close their loop within the last stage. Reset or any write
// to the configuration port clears the previous distance and loads the holdoff with four
// times holdoff_samples; writes are meant to be issued only while no word is in flight.

module echo_drop_detector_with_holdoff_unit
    import edd_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    // Input words.
    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    input  wire logic [IN_TDATA_W-1:0]  s_tdata,   // [19:0] echo_width_us, rest zero
    // Result words.
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    output logic [OUT_TDATA_W-1:0]      m_tdata,   // [0] hit, [16:1] drop_amount,
                                                   // [31:17] distance
    // Configuration writes.
    input  wire logic                   cfg_valid,
    output logic                        cfg_ready,
    input  wire logic [IDX_W-1:0]       cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

    cfg_t              cfg;
    restart_t          restart;
    logic              quot_valid;
    logic              quot_ready;
    logic [DIST_W-1:0] quotient;
    logic              hit;
    logic [DROP_W-1:0] drop;
    logic [DIST_W-1:0] distance;

    // Configuration registers.
    edd_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg),
        .restart   (restart)
    );

    // Width to distance.
    edd_divider u_divider (
        .clk           (clk),
        .rst_n         (rst_n),
        .distance_unit (cfg.distance_unit),
        .in_valid      (s_tvalid),
        .in_ready      (s_tready),
        .in_width      (s_tdata[ECHO_W-1:0]),
        .out_valid     (quot_valid),
        .out_ready     (quot_ready),
        .out_quotient  (quotient)
    );

    // Clamp, drop and holdoff.
    edd_detect u_detect (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg),
        .restart      (restart),
        .in_valid     (quot_valid),
        .in_ready     (quot_ready),
        .in_quotient  (quotient),
        .out_valid    (m_tvalid),
        .out_ready    (m_tready),
        .out_hit      (hit),
        .out_drop     (drop),
        .out_distance (distance)
    );

    assign m_tdata = {distance, drop, hit};

endmodule

`default_nettype wire

[rtl/core/edd_cfg.sv]
// Configuration registers of the echo drop detector.
// Depends on edd_pkg; raises a restart request for the detect stage.
`default_nettype none

module edd_cfg
    import edd_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [IDX_W-1:0]      cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    output cfg_t                       cfg,
    output restart_t                   restart
);

    cfg_t cfg_reg;
    cfg_t cfg_next;
    logic cfg_write;

    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;
    assign cfg       = cfg_reg;

    // Register decode.
    always_comb
    begin
        cfg_next = cfg_reg;
        unique case (cfg_index)
            REG_MAX_DISTANCE:    cfg_next.max_distance    = cfg_data[DIST_W-1:0];
            REG_DROP_THRESHOLD:  cfg_next.drop_threshold  = cfg_data[DIST_W-1:0];
            REG_HOLDOFF_SAMPLES: cfg_next.holdoff_samples = cfg_data[HOLD_SAMP_W-1:0];
            REG_DISTANCE_UNIT:   cfg_next.distance_unit   = cfg_data[0];
        endcase
    end

    // Any write restarts detection, with the holdoff taken from the new setting.
    assign restart.strobe  = cfg_write;
    assign restart.holdoff = HOLD_CNT_W'(HOLDOFF_RESET_FACTOR
                                         * int'(cfg_next.holdoff_samples));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.max_distance    <= MAX_DISTANCE_RST;
            cfg_reg.drop_threshold  <= DROP_THRESHOLD_RST;
            cfg_reg.holdoff_samples <= HOLDOFF_SAMPLES_RST;
            cfg_reg.distance_unit   <= DISTANCE_UNIT_RST;
        end
        else if (cfg_write)
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

`default_nettype wire

[rtl/core/edd_divider.sv]
// Two-stage width-to-distance converter: input register, then the quotient register.
// Depends on edd_pkg; divides by reciprocal multiplication.
`default_nettype none

module edd_divider
    import edd_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              distance_unit,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic [ECHO_W-1:0] in_width,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output logic [DIST_W-1:0]      out_quotient
);

    logic               width_valid_reg;
    logic [ECHO_W-1:0]  width_reg;
    logic               quot_valid_reg;
    logic [DIST_W-1:0]  quot_reg;
    logic               width_en;
    logic               quot_en;
    logic [RECIP_W-1:0] recip;
    logic [PROD_W-1:0]  product;
    logic [DIST_W-1:0]  quot_next;

    // Each stage loads when it is empty or its word moves on.
    assign quot_en  = !quot_valid_reg || out_ready;
    assign width_en = !width_valid_reg || quot_en;
    assign in_ready = width_en;

    // Quotient = (width * reciprocal) >> shift.
    assign recip   = distance_unit ? IN_RECIP : CM_RECIP;
    assign product = {{RECIP_W{1'b0}}, width_reg} * {{ECHO_W{1'b0}}, recip};
    assign quot_next = distance_unit ? DIST_W'(product >> IN_SHIFT)
                                     : DIST_W'(product >> CM_SHIFT);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_valid_reg <= 1'b0;
            quot_valid_reg  <= 1'b0;
        end
        else
        begin
            if (width_en)
            begin
                width_valid_reg <= in_valid;
            end
            if (quot_en)
            begin
                quot_valid_reg <= width_valid_reg;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (width_en && in_valid)
        begin
            width_reg <= in_width;
        end
        if (quot_en && width_valid_reg)
        begin
            quot_reg <= quot_next;
        end
    end

    assign out_valid    = quot_valid_reg;
    assign out_quotient = quot_reg;

endmodule

`default_nettype wire

[rtl/core/edd_detect.sv]
// Clamp, drop and holdoff stage of the echo drop detector, with the result register.
// Depends on edd_pkg; holds the previous distance and the holdoff countdown.
`default_nettype none

module edd_detect
    import edd_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire cfg_t              cfg,
    input  wire restart_t          restart,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic [DIST_W-1:0] in_quotient,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output logic                   out_hit,
    output logic [DROP_W-1:0]      out_drop,
    output logic [DIST_W-1:0]      out_distance
);

    logic                  out_valid_reg;
    logic                  hit_reg;
    logic [DROP_W-1:0]     drop_reg;
    logic [DIST_W-1:0]     dist_reg;
    logic [DIST_W-1:0]     prev_dist_reg;
    logic [DIST_W-1:0]     prev_dist_next;
    logic [HOLD_CNT_W-1:0] holdoff_reg;
    logic [HOLD_CNT_W-1:0] holdoff_next;
    logic [DIST_W-1:0]     cur_dist;
    logic signed [DROP_W-1:0] drop;
    logic                  hit;
    logic                  take;

    assign in_ready = !out_valid_reg || out_ready;
    assign take     = in_valid && in_ready;

    // Clamp and drop from the previous distance.
    assign cur_dist = (in_quotient > cfg.max_distance) ? cfg.max_distance : in_quotient;
    assign drop = $signed({1'b0, prev_dist_reg}) - $signed({1'b0, cur_dist});
    assign hit  = (holdoff_reg == '0) && (drop > $signed({1'b0, cfg.drop_threshold}));

    // State update: a restart wins; else a taken word counts down or rearms on a hit.
    always_comb
    begin
        prev_dist_next = prev_dist_reg;
        holdoff_next   = holdoff_reg;
        if (restart.strobe)
        begin
            prev_dist_next = '0;
            holdoff_next   = restart.holdoff;
        end
        else if (take)
        begin
            prev_dist_next = cur_dist;
            if (holdoff_reg != '0)
            begin
                holdoff_next = holdoff_reg - 1'b1;
            end
            else if (hit)
            begin
                holdoff_next = HOLD_CNT_W'(cfg.holdoff_samples);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            prev_dist_reg <= '0;
            holdoff_reg   <= HOLDOFF_CNT_RST;
        end
        else
        begin
            if (in_ready)
            begin
                out_valid_reg <= in_valid;
            end
            prev_dist_reg <= prev_dist_next;
            holdoff_reg   <= holdoff_next;
        end
    end

    // Result register.
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            hit_reg  <= hit;
            drop_reg <= drop;
            dist_reg <= cur_dist;
        end
    end

    assign out_valid    = out_valid_reg;
    assign out_hit      = hit_reg;
    assign out_drop     = drop_reg;
    assign out_distance = dist_reg;

endmodule

`default_nettype wire

[tb/tb_echo_drop_detector_with_holdoff_unit.sv]
// Self-checking testbench for echo_drop_detector_with_holdoff_unit: a directed table, then
// random echo streams shaped into level runs and sudden drops under changing register settings.
// Depends on edd_pkg and the RTL of the block; each result is checked against the model or its row.
`timescale 1ns / 1ps

module tb_echo_drop_detector_with_holdoff_unit;
    import edd_pkg::*;

    localparam int CLK_HALF         = 6;
    localparam int RESET_CYCLES     = 2;
    localparam int CYCLE_LIMIT      = 200000;
    localparam int TAIL_CYCLES      = 10;
    localparam int LONG_HOLD_CYCLES = 64;
    localparam int RANDOM_PHASES    = 8;
    localparam int WORDS_PER_PHASE  = 66;
    localparam int MAX_REPORTS      = 150;
    localparam int ECHO_MAX         = (1 << ECHO_W) - 1;
    localparam int CFG_MAX          = (1 << CFG_DATA_W) - 1;
    localparam int NUM_ROWS         = 26;

    // One result word, split into its fields.
    typedef struct packed {
        logic              hit;
        logic [DROP_W-1:0] drop;
        logic [DIST_W-1:0] distance;
    } result_t;

    // What the sender attaches to each echo word it offers.
    typedef struct packed {
        bit      typed;
        result_t res;
    } word_tag_t;

    typedef enum bit {ROW_ECHO, ROW_CFG} row_kind_e;

    // One row of the directed table.
    typedef struct packed {
        row_kind_e         kind;
        logic [IDX_W-1:0]  reg_idx;   // unused on echo rows
        logic [ECHO_W-1:0] arg;       // echo width, or register data
        bit                typed;     // expected result given in the row
        logic              hit;
        logic [DROP_W-1:0] drop;
        logic [DIST_W-1:0] distance;
    } row_t;

    // Directed stimulus. Expected results are given where they are plain from the rules.
    localparam row_t DIRECTED [NUM_ROWS] = '{
        // Reset settings: a long holdoff masks everything at first.
        '{ROW_ECHO, '0, 20'd0,      1'b1, 1'b0, 16'd0,       15'd0},
        '{ROW_ECHO, '0, 20'hFFFFF,  1'b1, 1'b0, -16'sd400,   15'd400},
        '{ROW_ECHO, '0, 20'd23200,  1'b1, 1'b0, 16'd0,       15'd400},
        '{ROW_ECHO, '0, 20'd57,     1'b1, 1'b0, 16'd400,     15'd0},
        // No holdoff: drops above, at and just over the default threshold.
        '{ROW_CFG,  REG_HOLDOFF_SAMPLES, 20'd0, 1'b0, 1'b0, 16'd0, 15'd0},
        '{ROW_ECHO, '0, 20'd580,    1'b0, 1'b0, 16'd0,       15'd0},
        '{ROW_ECHO, '0, 20'd0,      1'b0, 1'b0, 16'd0,       15'd0},
        '{ROW_ECHO, '0, 20'd290,    1'b0, 1'b0, 16'd0,       15'd0},
        '{ROW_ECHO, '0, 20'd0,      1'b0, 1'b0, 16'd0,       15'd0},
        '{ROW_ECHO, '0, 20'd348,    1'b0, 1'b0, 16'd0,       15'd0},
        '{ROW_ECHO, '0, 20'd0,      1'b0, 1'b0, 16'd0,       15'd0},
        // Inches, with the divisor boundary.
        '{ROW_CFG,  REG_DISTANCE_UNIT, 20'd1, 1'b0, 1'b0, 16'd0, 15'd0},
        '{ROW_ECHO, '0, 20'hFFFFF,  1'b0, 1'b0, 16'd0,       15'd0},
        '{ROW_ECHO, '0, 20'd147,    1'b0, 1'b0, 16'd0,       15'd0},
        '{ROW_ECHO, '0, 20'd148,    1'b0, 1'b0, 16'd0,       15'd0},
        // Clamp above its range and a zero threshold: the largest possible drop.
        '{ROW_CFG,  REG_MAX_DISTANCE, 20'd32767, 1'b0, 1'b0, 16'd0, 15'd0},
        '{ROW_CFG,  REG_DISTANCE_UNIT, 20'd0,    1'b0, 1'b0, 16'd0, 15'd0},
        '{ROW_CFG,  REG_DROP_THRESHOLD, 20'd0,   1'b0, 1'b0, 16'd0, 15'd0},
        '{ROW_ECHO, '0, 20'hFFFFF,  1'b1, 1'b0, -16'sd18078, 15'd18078},
        '{ROW_ECHO, '0, 20'd0,      1'b1, 1'b1, 16'd18078,   15'd0},
        // Threshold at its top: no drop can exceed it.
        '{ROW_CFG,  REG_DROP_THRESHOLD, 20'd32767, 1'b0, 1'b0, 16'd0, 15'd0},
        '{ROW_ECHO, '0, 20'hFFFFF,  1'b0, 1'b0, 16'd0,       15'd0},
        '{ROW_ECHO, '0, 20'd0,      1'b0, 1'b0, 16'd0,       15'd0},
        // Longest holdoff and a zero clamp.
        '{ROW_CFG,  REG_HOLDOFF_SAMPLES, 20'd255, 1'b0, 1'b0, 16'd0, 15'd0},
        '{ROW_CFG,  REG_MAX_DISTANCE, 20'd0,      1'b0, 1'b0, 16'd0, 15'd0},
        '{ROW_ECHO, '0, 20'hFFFFF,  1'b1, 1'b0, 16'd0,       15'd0}
    };

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata = '0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [IDX_W-1:0]       cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;

    // Model state: register copies and detection state.
    logic [DIST_W-1:0]      cfg_max;
    logic [DIST_W-1:0]      cfg_thr;
    logic [HOLD_SAMP_W-1:0] cfg_hold;
    logic                   cfg_unit;
    logic [DIST_W-1:0]      prev_dist;
    logic [HOLD_CNT_W-1:0]  holdoff_left;

    word_tag_t word_tags[$];
    result_t   pending_results[$];

    bit idle_on = 1'b1;
    bit long_hold_req = 1'b0;
    int echo_level = 0;
    int failures = 0;
    int words_in = 0;
    int results_out = 0;
    int hits_seen = 0;
    int cfg_writes = 0;
    int cycle_count = 0;

    echo_drop_detector_with_holdoff_unit uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #(CLK_HALF) clk = ~clk;

    // Clear the previous distance and load the long holdoff from the current setting.
    function automatic void rearm_holdoff();
        prev_dist    = '0;
        holdoff_left = HOLD_CNT_W'(HOLDOFF_RESET_FACTOR * int'(cfg_hold));
    endfunction

    function automatic void apply_register(input logic [IDX_W-1:0] idx,
                                           input logic [CFG_DATA_W-1:0] data);
        case (idx)
            REG_MAX_DISTANCE:    cfg_max  = DIST_W'(data);
            REG_DROP_THRESHOLD:  cfg_thr  = DIST_W'(data);
            REG_HOLDOFF_SAMPLES: cfg_hold = data[HOLD_SAMP_W-1:0];
            REG_DISTANCE_UNIT:   cfg_unit = data[0];
            default:             return;
        endcase
        rearm_holdoff();
    endfunction

    // Distance, drop and hit for one echo width; advances the holdoff and previous distance.
    function automatic result_t predict_distance_drop(input logic [ECHO_W-1:0] echo);
        int unsigned width;
        int unsigned clamped;
        int          drop;
        result_t     r;
        width   = echo;
        clamped = width / (cfg_unit ? IN_DIVISOR : CM_DIVISOR);
        if (clamped > cfg_max)
            clamped = cfg_max;
        drop  = int'(prev_dist) - int'(clamped);
        r.hit = 1'b0;
        if (holdoff_left == '0)
        begin
            if (drop > int'(cfg_thr))
            begin
                holdoff_left = HOLD_CNT_W'(cfg_hold);
                r.hit        = 1'b1;
            end
        end
        else
            holdoff_left = holdoff_left - 1'b1;
        prev_dist  = DIST_W'(clamped);
        r.drop     = DROP_W'(drop);
        r.distance = DIST_W'(clamped);
        return r;
    endfunction

    function automatic void report_mismatch(input string field, input int want, input int got);
        failures++;
        if (failures <= MAX_REPORTS)
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
    endfunction

    // Compare one result word with the oldest expectation, field by field.
    function automatic void check_result(input logic [OUT_TDATA_W-1:0] word);
        result_t got;
        result_t want;
        got.hit      = word[0];
        got.drop     = word[DROP_W:1];
        got.distance = word[DROP_W+DIST_W:DROP_W+1];
        results_out++;
        if (got.hit === 1'b1)
            hits_seen++;
        if (pending_results.size() == 0)
        begin
            failures++;
            $display("%0t: result word with none expected, expected nothing, got 0x%h",
                     $time, word);
            return;
        end
        want = pending_results.pop_front();
        if (got.hit !== want.hit)
            report_mismatch("hit", int'(want.hit), int'(got.hit));
        if (got.drop !== want.drop)
            report_mismatch("drop_amount", int'($signed(want.drop)), int'($signed(got.drop)));
        if (got.distance !== want.distance)
            report_mismatch("distance", int'(want.distance), int'(got.distance));
    endfunction

    // Watch all three channels; the model follows every accepted word.
    always @(posedge clk)
    begin : monitor
        word_tag_t tag;
        result_t   want;
        if (!rst_n)
        begin
            cfg_max  = MAX_DISTANCE_RST;
            cfg_thr  = DROP_THRESHOLD_RST;
            cfg_hold = HOLDOFF_SAMPLES_RST;
            cfg_unit = DISTANCE_UNIT_RST;
            rearm_holdoff();
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                apply_register(cfg_index, cfg_data);
                cfg_writes++;
            end
            if (s_tvalid && s_tready)
            begin
                tag  = word_tags.pop_front();
                want = predict_distance_drop(s_tdata[ECHO_W-1:0]);
                if (tag.typed)
                    want = tag.res;
                pending_results.push_back(want);
                words_in++;
            end
            if (m_tvalid && m_tready)
                check_result(m_tdata);
        end
    end

    // Receiver: random stalls while idle_on is set, one long hold on request, counted here.
    initial
    begin : receiver
        int unsigned stall;
        wait (rst_n === 1'b1);
        forever
        begin
            stall = idle_on ? $urandom_range(0, 3) : 0;
            if (long_hold_req)
            begin
                stall         = LONG_HOLD_CYCLES;
                long_hold_req = 1'b0;
            end
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            @(posedge clk);
            while (!m_tvalid) @(posedge clk);
        end
    end

    // Run limit.
    initial
    begin : watchdog
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Run stopped after %0d cycles with %0d results outstanding",
                 cycle_count, pending_results.size());
        $display("TEST FAILED");
        $finish;
    end

    // Offer one echo word, after a random gap while idle_on is set, and wait until it is taken.
    task automatic send_echo(input logic [ECHO_W-1:0] echo, input bit typed,
                             input result_t typed_res);
        int unsigned gap;
        word_tag_t   tag;
        gap       = idle_on ? $urandom_range(0, 3) : 0;
        cfg_valid <= 1'b0;
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        tag.typed = typed;
        tag.res   = typed_res;
        word_tags.push_back(tag);
        s_tvalid <= 1'b1;
        s_tdata  <= IN_TDATA_W'(echo);
        @(posedge clk);
        while (!s_tready) @(posedge clk);
    endtask

    // Register write; valid stays up so that writes can follow back to back.
    task automatic write_register(input logic [IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
    endtask

    // Stop offering words and wait until every expected result has come back.
    task automatic wait_for_results();
        s_tvalid <= 1'b0;
        while (word_tags.size() != 0 || pending_results.size() != 0) @(posedge clk);
    endtask

    // Mostly a setting in a useful range, sometimes any 15-bit value.
    function automatic logic [CFG_DATA_W-1:0] register_value(input int useful);
        if ($urandom_range(0, 4) == 0)
            return CFG_DATA_W'($urandom_range(0, CFG_MAX));
        return CFG_DATA_W'(useful);
    endfunction

    task automatic configure_phase(input int phase);
        logic [3:0] pick;
        if (phase == 0)
        begin
            // Top of every stated range.
            write_register(REG_MAX_DISTANCE, 15'd20000);
            write_register(REG_DROP_THRESHOLD, 15'd20000);
            write_register(REG_HOLDOFF_SAMPLES, 15'd255);
            write_register(REG_DISTANCE_UNIT, 15'd0);
        end
        else if (phase == 1)
        begin
            // Most sensitive detector, in inches.
            write_register(REG_MAX_DISTANCE, 15'd600);
            write_register(REG_DROP_THRESHOLD, 15'd0);
            write_register(REG_HOLDOFF_SAMPLES, 15'd0);
            write_register(REG_DISTANCE_UNIT, 15'd1);
        end
        else
        begin
            pick = 4'($urandom_range(1, 15));
            if (pick[0])
                write_register(REG_MAX_DISTANCE, register_value($urandom_range(16, 700)));
            if (pick[1])
                write_register(REG_DROP_THRESHOLD, register_value($urandom_range(0, 24)));
            if (pick[2])
                write_register(REG_HOLDOFF_SAMPLES, register_value($urandom_range(0, 6)));
            if (pick[3])
                write_register(REG_DISTANCE_UNIT, register_value($urandom_range(0, 1)));
        end
    endtask

    // Next echo width: level runs with jitter, sudden drops near the threshold,
    // jumps, missing echoes and some fully random widths.
    function automatic logic [ECHO_W-1:0] shape_echo();
        int unsigned divisor;
        int unsigned pick;
        int          top;
        int          step;
        longint      width;
        divisor = cfg_unit ? IN_DIVISOR : CM_DIVISOR;
        top     = int'(cfg_max) + 8;
        if (top > ECHO_MAX / int'(divisor))
            top = ECHO_MAX / int'(divisor);
        pick = $urandom_range(0, 99);
        if (pick < 12)
            return ECHO_W'($urandom_range(0, ECHO_MAX));
        if (pick < 18)
            return '0;
        if (pick < 42)
        begin
            if ($urandom_range(0, 2) == 0)
                step = int'(cfg_thr) + int'($urandom_range(0, 1));
            else
                step = int'($urandom_range(0, 2 * int'(cfg_thr) + 4));
            echo_level = (step > echo_level) ? 0 : echo_level - step;
        end
        else if (pick < 52)
            echo_level = int'($urandom_range(0, top));
        else
            echo_level += int'($urandom_range(0, 4)) - 2;
        if (echo_level < 0)
            echo_level = 0;
        if (echo_level > top)
            echo_level = top;
        width = longint'(echo_level) * divisor + $urandom_range(0, divisor - 1);
        if (width > ECHO_MAX)
            width = ECHO_MAX;
        return ECHO_W'(width);
    endfunction

    // Stimulus.
    initial
    begin : stimulus
        result_t typed_res;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // Directed table.
        for (int i = 0; i < NUM_ROWS; i++)
        begin
            if (DIRECTED[i].kind == ROW_CFG)
            begin
                wait_for_results();
                write_register(DIRECTED[i].reg_idx, CFG_DATA_W'(DIRECTED[i].arg));
            end
            else
            begin
                typed_res.hit      = DIRECTED[i].hit;
                typed_res.drop     = DIRECTED[i].drop;
                typed_res.distance = DIRECTED[i].distance;
                send_echo(DIRECTED[i].arg, DIRECTED[i].typed, typed_res);
            end
        end

        // Random phases, each under its own register setting.
        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            wait_for_results();
            configure_phase(phase);
            idle_on    = (phase != 2);
            echo_level = int'(cfg_max) / 2;
            if (phase == 4)
                long_hold_req = 1'b1;
            for (int n = 0; n < WORDS_PER_PHASE; n++)
            begin
                if (phase == 5 && n == WORDS_PER_PHASE / 2)
                    wait_for_results();
                send_echo(shape_echo(), 1'b0, '0);
            end
        end

        wait_for_results();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (pending_results.size() != 0)
        begin
            failures += pending_results.size();
            $display("%0t: %0d expected results never arrived", $time, pending_results.size());
        end

        $display("Sent %0d echo words through %0d register writes; checked %0d results, %0d hits.",
                 words_in, cfg_writes, results_out, hits_seen);
        $display("Both units, clamp and threshold extremes, holdoff windows and stalled output.");
        if (failures == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
